/* rtl/core/etbc_pkg.sv */
// Shared widths, register codes and stage types of the burst capture core.
package etbc_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int ENERGY_W   = 32;
	localparam int FACTOR_W   = 8;
	localparam int PLEN_W     = 13;
	localparam int CFG_DATA_W = 13;
	localparam int CFG_IDX_W  = 1;

	localparam logic [FACTOR_W-1:0] FACTOR_RESET = 8'd10;
	localparam logic [PLEN_W-1:0]   PLEN_RESET   = 13'd256;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TRIGGER_FACTOR = 1'b0,
		REG_PACKET_LENGTH  = 1'b1
	} cfg_reg_t;

	// One request as it leaves the energy stage
	typedef struct packed {
		logic                       valid;
		logic signed [SAMPLE_W-1:0] i;
		logic signed [SAMPLE_W-1:0] q;
		logic [ENERGY_W-1:0]        energy;
		logic [ENERGY_W-1:0]        old;
		logic                       warm;
	} s2_item_t;

endpackage

/* rtl/core/etbc_energy.sv */
// Input register, sample energy and the energy history delay line.
module etbc_energy import etbc_pkg::*; #(
	parameter int HISTORY_LEN = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic signed [SAMPLE_W-1:0] sample_i,
	input  logic signed [SAMPLE_W-1:0] sample_q,
	input  logic                       s2_done,
	output s2_item_t                   s2
);

	localparam int PTR_W  = (HISTORY_LEN > 1) ? $clog2(HISTORY_LEN) : 1;
	localparam int FILL_W = $clog2(HISTORY_LEN + 1);

	logic                       v1_s1;
	logic signed [SAMPLE_W-1:0] i_s1, q_s1;
	logic                       v2_s2;
	logic signed [SAMPLE_W-1:0] i_s2, q_s2;
	logic [ENERGY_W-1:0]        energy_s2, old_s2;
	logic                       warm_s2;
	logic [PTR_W-1:0]           ptr_q;
	logic [FILL_W-1:0]          fill_q;
	logic [ENERGY_W-1:0]        hist_mem [HISTORY_LEN];

	logic                       en2, en1, adv1;
	logic signed [2*SAMPLE_W-1:0] pi, pq;
	logic [ENERGY_W-1:0]        energy;
	logic                       full;

	// Stage enables: a stage loads when empty or when its request moves on
	assign en2      = !v2_s2 || s2_done;
	assign en1      = !v1_s1 || en2;
	assign adv1     = v1_s1 && en2;
	assign in_stall = !en1;

	// Energy of the registered sample
	assign pi     = i_s1 * i_s1;
	assign pq     = q_s1 * q_s1;
	assign energy = ENERGY_W'(pi) + ENERGY_W'(pq);
	assign full   = (fill_q == FILL_W'(HISTORY_LEN));

	// Valid bits, write position and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1  <= 1'b0;
			v2_s2  <= 1'b0;
			ptr_q  <= '0;
			fill_q <= '0;
		end else begin
			if (en1) v1_s1 <= in_valid;
			if (en2) v2_s2 <= v1_s1;
			if (adv1) begin
				if (ptr_q == PTR_W'(HISTORY_LEN - 1)) ptr_q <= '0;
				else ptr_q <= ptr_q + PTR_W'(1);
				if (!full) fill_q <= fill_q + FILL_W'(1);
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (en1 && in_valid) begin
			i_s1 <= sample_i;
			q_s1 <= sample_q;
		end
		if (adv1) begin
			i_s2      <= i_s1;
			q_s2      <= q_s1;
			energy_s2 <= energy;
			warm_s2   <= full;
		end
	end

	// History memory: read the leaving entry, then overwrite it
	always_ff @(posedge clk) begin
		if (adv1) begin
			old_s2          <= hist_mem[ptr_q];
			hist_mem[ptr_q] <= energy;
		end
	end

	// Entries not yet written count as zero
	always_comb begin
		s2.valid  = v2_s2;
		s2.i      = i_s2;
		s2.q      = q_s2;
		s2.energy = energy_s2;
		s2.old    = warm_s2 ? old_s2 : '0;
		s2.warm   = warm_s2;
	end

endmodule

/* rtl/core/etbc_detect.sv */
// Running energy sum, trigger test, capture control and result register.
module etbc_detect import etbc_pkg::*; #(
	parameter int HISTORY_LEN = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_DATA_W-1:0]      cfg_data,
	input  s2_item_t                   s2,
	output logic                       s2_done,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [SAMPLE_W-1:0] out_i,
	output logic signed [SAMPLE_W-1:0] out_q,
	output logic                       packet_end
);

	localparam int SUM_W = ENERGY_W + $clog2(HISTORY_LEN);
	localparam int CMP_W = FACTOR_W + SUM_W;

	logic [FACTOR_W-1:0]        factor_q;
	logic [PLEN_W-1:0]          plen_q;
	logic [SUM_W-1:0]           sum_q;
	logic                       capturing_q;
	logic [PLEN_W-1:0]          count_q;
	logic                       out_valid_q, out_end_q;
	logic signed [SAMPLE_W-1:0] out_i_q, out_q_q;

	logic [CMP_W-1:0]  lhs, rhs;
	logic              trig, cap_now, res, o_adv;
	logic [PLEN_W-1:0] cnt, cnt_inc;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			factor_q <= FACTOR_RESET;
			plen_q   <= PLEN_RESET;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_TRIGGER_FACTOR: factor_q <= cfg_data[FACTOR_W-1:0];
				REG_PACKET_LENGTH:  plen_q   <= cfg_data[PLEN_W-1:0];
			endcase
		end
	end

	// Trigger test against the history before this sample
	assign lhs     = CMP_W'(s2.energy) * CMP_W'(HISTORY_LEN);
	assign rhs     = CMP_W'(factor_q) * CMP_W'(sum_q);
	assign trig    = s2.valid && s2.warm && !capturing_q && (lhs > rhs);
	assign cap_now = capturing_q || trig;
	assign cnt     = trig ? '0 : count_q;
	assign cnt_inc = cnt + PLEN_W'(1);
	assign res     = cap_now && (cnt < plen_q);

	// Handshake: result register frees up when empty or taken
	assign o_adv   = !out_valid_q || !out_stall;
	assign s2_done = s2.valid && (!res || o_adv);

	// Sum and capture state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q       <= '0;
			capturing_q <= 1'b0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (s2_done) begin
				sum_q <= sum_q - SUM_W'(s2.old) + SUM_W'(s2.energy);
				if (cap_now) begin
					if (res) begin
						capturing_q <= 1'b1;
						count_q     <= cnt_inc;
					end else begin
						capturing_q <= 1'b0;
						count_q     <= '0;
					end
				end
			end
			if (o_adv) out_valid_q <= s2.valid && res;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (o_adv && s2.valid && res) begin
			out_i_q   <= s2.i;
			out_q_q   <= s2.q;
			out_end_q <= (cnt_inc == plen_q);
		end
	end

	assign out_valid  = out_valid_q;
	assign out_i      = out_i_q;
	assign out_q      = out_q_q;
	assign packet_end = out_end_q;

	// Checks
	a_idle_count_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!capturing_q |-> count_q == '0)
		else $error("capture count nonzero while idle");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(s2_done && res) |=> out_valid_q)
		else $error("captured sample not presented");

	a_end_at_length: assert property (@(posedge clk) disable iff (!arst_n)
		(s2_done && res && cnt_inc == plen_q) |=> (out_end_q && count_q == $past(plen_q)))
		else $error("packet end does not match packet length");

endmodule

/* rtl/core/energy_triggered_burst_capture_core.sv */
// Top level of the energy-triggered burst capture core.
// Accepts one I/Q sample per clock unless stalled and returns each captured sample through
// the input, energy and result registers; the running-sum and trigger loop sets this rate.
// A sample triggers once HISTORY_LEN samples have passed, when its energy times HISTORY_LEN
// exceeds trigger_factor times the sum of the previous HISTORY_LEN energies; packet_length
// samples are then passed with packet_end on the last, and the following sample is swallowed.
// The history is a HISTORY_LEN x 32-bit memory with no clearing pass: a fill count treats
// unwritten entries as zero, so the block is ready straight from reset.
module energy_triggered_burst_capture_core import etbc_pkg::*; #(
	parameter int HISTORY_LEN = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_DATA_W-1:0]      cfg_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic signed [SAMPLE_W-1:0] sample_i,
	input  logic signed [SAMPLE_W-1:0] sample_q,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [SAMPLE_W-1:0] out_i,
	output logic signed [SAMPLE_W-1:0] out_q,
	output logic                       packet_end
);

	s2_item_t s2;
	logic     s2_done;

	// Energy and history stage
	etbc_energy #(
		.HISTORY_LEN(HISTORY_LEN)
	) u_energy (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sample_i (sample_i),
		.sample_q (sample_q),
		.s2_done  (s2_done),
		.s2       (s2)
	);

	// Detection and capture stage
	etbc_detect #(
		.HISTORY_LEN(HISTORY_LEN)
	) u_detect (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.s2         (s2),
		.s2_done    (s2_done),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_i      (out_i),
		.out_q      (out_q),
		.packet_end (packet_end)
	);

endmodule

/* tb/sv/testbench.sv */
// Self-checking testbench for the energy-triggered burst capture core.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import etbc_pkg::*;

	localparam int HIST_LEN   = 64;
	localparam int RUN_LIMIT  = 500000;
	localparam int DRAIN_WAIT = 8;

	typedef struct {
		logic signed [SAMPLE_W-1:0] i;
		logic signed [SAMPLE_W-1:0] q;
	} iq_sample_t;

	typedef struct {
		logic signed [SAMPLE_W-1:0] i;
		logic signed [SAMPLE_W-1:0] q;
		logic                       last;
	} cap_sample_t;

	logic                       clk;
	logic                       arst_n     = 1'b0;
	logic                       cfg_we     = 1'b0;
	logic [CFG_IDX_W-1:0]       cfg_index  = '0;
	logic [CFG_DATA_W-1:0]      cfg_data   = '0;
	logic                       in_valid   = 1'b0;
	logic                       in_stall;
	logic signed [SAMPLE_W-1:0] sample_i   = '0;
	logic signed [SAMPLE_W-1:0] sample_q   = '0;
	logic                       out_valid;
	logic                       out_stall  = 1'b0;
	logic signed [SAMPLE_W-1:0] out_i;
	logic signed [SAMPLE_W-1:0] out_q;
	logic                       packet_end;

	// Stimulus and expectation stores
	iq_sample_t  pending_q[$];
	cap_sample_t capture_q[$];
	iq_sample_t  next_req;
	cap_sample_t want;
	logic        in_taken = 1'b0;
	int          send_idle = 17;
	int          recv_idle = 87;
	int          fail_count = 0;
	int          items_made = 0;
	int          cycle_count = 0;

	// Predictor state
	logic [ENERGY_W-1:0] hist_energy [HIST_LEN];
	logic [37:0]         energy_total;
	int                  warm_left;
	int                  hist_wr;
	logic                in_capture;
	logic [PLEN_W-1:0]   cap_count;
	logic [FACTOR_W-1:0] model_factor;
	logic [PLEN_W-1:0]   model_plen;

	energy_triggered_burst_capture_core #(
		.HISTORY_LEN(HIST_LEN)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.sample_i  (sample_i),
		.sample_q  (sample_q),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_i     (out_i),
		.out_q     (out_q),
		.packet_end(packet_end)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Advance the energy history for one accepted request and queue any captured sample
	task automatic predict_capture(input logic signed [SAMPLE_W-1:0] si,
		input logic signed [SAMPLE_W-1:0] sq);
		int                  a;
		int                  b;
		logic [ENERGY_W-1:0] e;
		logic [63:0]         lhs;
		logic [63:0]         rhs;
		logic                trig;
		cap_sample_t         s;
		a   = si;
		b   = sq;
		e   = 32'(a * a) + 32'(b * b);
		lhs = 64'(e) * 64'(HIST_LEN);
		rhs = 64'(model_factor) * 64'(energy_total);
		// trigger test uses the history before this sample
		trig = (warm_left == 0) && !in_capture && (lhs > rhs);
		if (warm_left > 0)
			warm_left--;
		energy_total = energy_total - 38'(hist_energy[hist_wr]) + 38'(e);
		hist_energy[hist_wr] = e;
		hist_wr = (hist_wr == HIST_LEN - 1) ? 0 : hist_wr + 1;
		if (trig) begin
			in_capture = 1'b1;
			cap_count  = '0;
		end
		if (in_capture) begin
			if (cap_count >= model_plen) begin
				// ending sample is swallowed
				in_capture = 1'b0;
				cap_count  = '0;
			end else begin
				cap_count++;
				s.i    = si;
				s.q    = sq;
				s.last = (cap_count == model_plen);
				capture_q.insert(capture_q.size(), s);
			end
		end
	endtask

	// Acceptance tracking, predictor and result checker
	always @(posedge clk) begin
		if (!arst_n) begin
			for (int k = 0; k < HIST_LEN; k++)
				hist_energy[k] = '0;
			energy_total = '0;
			warm_left    = HIST_LEN;
			hist_wr      = 0;
			in_capture   = 1'b0;
			cap_count    = '0;
			model_factor = FACTOR_RESET;
			model_plen   = PLEN_RESET;
			in_taken    <= 1'b0;
		end else begin
			in_taken <= in_valid && !in_stall;
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_TRIGGER_FACTOR: model_factor = cfg_data[FACTOR_W-1:0];
					REG_PACKET_LENGTH:  model_plen   = cfg_data[PLEN_W-1:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (capture_q.size() == 0) begin
					$error("unexpected result: out_i=%0d out_q=%0d packet_end=%0b",
						out_i, out_q, packet_end);
					fail_count++;
				end else begin
					want = capture_q.pop_front();
					if (out_i !== want.i) begin
						$error("out_i: expected %0d, got %0d", want.i, out_i);
						fail_count++;
					end
					if (out_q !== want.q) begin
						$error("out_q: expected %0d, got %0d", want.q, out_q);
						fail_count++;
					end
					if (packet_end !== want.last) begin
						$error("packet_end: expected %0b, got %0b", want.last, packet_end);
						fail_count++;
					end
				end
			end
			if (in_valid && !in_stall)
				predict_capture(sample_i, sample_q);
		end
	end

	// Sample driver: holds a request until it is taken
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && !in_taken) begin
			// stalled request stays put
		end else if (pending_q.size() == 0 || $urandom_range(0, 99) < send_idle) begin
			in_valid <= 1'b0;
		end else begin
			next_req = pending_q.pop_front();
			in_valid <= 1'b1;
			sample_i <= next_req.i;
			sample_q <= next_req.q;
		end
	end

	// Result receiver stalls
	always @(negedge clk) begin
		if (!arst_n)
			out_stall <= 1'b0;
		else
			out_stall <= ($urandom_range(0, 99) < recv_idle);
	end

	// Run limit
	initial begin
		while (cycle_count < RUN_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("testbench failed");
		$finish;
	end

	task automatic push_sample(input int si, input int sq);
		iq_sample_t s;
		s.i = 16'(si);
		s.q = 16'(sq);
		pending_q.insert(pending_q.size(), s);
		items_made++;
	endtask

	// Quiet noise floor with occasional wild samples, broken by bursts of random full-range samples
	task automatic gen_mix(input int n);
		int left;
		int run;
		int amp;
		left = n;
		while (left > 0) begin
			run = $urandom_range(10, 90);
			amp = $urandom_range(0, 200);
			for (int k = 0; k < run && left > 0; k++) begin
				if ($urandom_range(0, 15) == 0)
					push_sample($urandom, $urandom);
				else
					push_sample(int'($urandom_range(0, 2 * amp)) - amp,
						int'($urandom_range(0, 2 * amp)) - amp);
				left--;
			end
			run = $urandom_range(1, 24);
			for (int k = 0; k < run && left > 0; k++) begin
				push_sample($urandom, $urandom);
				left--;
			end
		end
	endtask

	// Both register writes on consecutive cycles, factor upper data bits as junk
	task automatic set_config(input int factor, input int plen);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_TRIGGER_FACTOR;
		cfg_data  <= {5'($urandom), 8'(factor)};
		@(negedge clk);
		cfg_index <= REG_PACKET_LENGTH;
		cfg_data  <= 13'(plen);
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	// Sender holds off until every request is in and every result is out
	task automatic wait_drained();
		do
			@(posedge clk);
		while (pending_q.size() != 0 || in_valid || capture_q.size() != 0);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic set_idle(input int snd, input int rcv);
		send_idle = snd;
		recv_idle = rcv;
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset register values; extremes fall inside warm-up and must not trigger
		set_idle(17, 87);
		push_sample(32767, 32767);
		push_sample(-32768, -32768);
		push_sample(-32768, 32767);
		push_sample(32767, -32768);
		push_sample(0, 0);
		push_sample(-1, -1);
		push_sample(1, 0);
		push_sample(0, 1);
		push_sample(-32768, 0);
		push_sample(0, -32768);
		gen_mix(100);
		wait_drained();

		// Zero factor with zero length: every nonzero sample triggers and is swallowed
		set_config(0, 0);
		push_sample(0, 0);
		push_sample(1, 0);
		push_sample(0, 1);
		push_sample(0, 0);
		push_sample(32767, -32768);
		push_sample(-32768, -32768);
		gen_mix(30);
		wait_drained();

		set_config(255, 1);
		gen_mix(60);
		wait_drained();

		set_config(0, 2);
		gen_mix(30);
		wait_drained();

		// Long capture left open, then cut short by a smaller length
		set_idle(87, 17);
		set_config(10, 4096);
		gen_mix(100);
		wait_drained();

		set_config(10, 3);
		gen_mix(40);
		wait_drained();

		set_config(1, 8191);
		gen_mix(40);
		wait_drained();

		set_config(20, 12);
		gen_mix(40);
		wait_drained();

		// Free-running phases with random settings
		set_idle(0, 0);
		while (items_made < 500) begin
			if ($urandom_range(0, 3) == 0)
				set_config($urandom_range(0, 255), $urandom_range(1, 32));
			else
				set_config($urandom_range(2, 30), $urandom_range(1, 32));
			gen_mix(60);
			wait_drained();
		end

		if (capture_q.size() != 0)
			fail_count++;
		if (fail_count == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule
